FILE: src/agss_pkg.sv
// package for the all-gather step schedule block
// types, constants and helper functions shared by all modules and interfaces
// no dependencies
`default_nettype none

package agss_pkg;

  localparam int MAX_RANKS   = 64;
  localparam int FIELD_LIMIT = 64;
  localparam int SIZE_CAP    = (MAX_RANKS < FIELD_LIMIT) ? MAX_RANKS : FIELD_LIMIT;

  localparam int N_W     = 7;   // rank count, up to 64
  localparam int IDX_W   = 6;   // rank or slice index
  localparam int STEP_W  = 3;
  localparam int CNT_W   = 6;
  localparam int CFG_W   = 7;   // widest register
  localparam int CFGI_W  = 1;
  localparam int RED_W   = 3;   // shift count of the modulo reduction
  localparam int UNIT_W  = N_W + (1 << RED_W) - 2;  // holds n shifted by up to IDX_W-1
  localparam int MAX_STEPS = 6;

  localparam logic [CFGI_W-1:0] CFG_RANK_SIZE = 1'd0;
  localparam logic [CFGI_W-1:0] CFG_MY_RANK   = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SEND,
    ST_RECV,
    ST_DDM,
    ST_OUT,
    ST_NEXT_TX,
    ST_NEXT_RX
  } state_t;

  typedef struct packed {
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
    logic [UNIT_W-1:0] c;
    logic [UNIT_W-1:0] m;
  } unit_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] send_to;
    logic [IDX_W-1:0] recv_from;
    logic [CNT_W-1:0] slice_count;
    logic [IDX_W-1:0] tx_slice;
    logic [IDX_W-1:0] rx_slice;
    logic             last;
    logic             status;
  } result_t;

  // effective group size: zero reads as one, large values saturate
  function automatic logic [N_W-1:0] eff_size(input logic [CFG_W-1:0] rs);
    logic [N_W-1:0] n;
    n = rs;
    if (rs == '0) begin
      n = N_W'(1);
    end else if (rs > CFG_W'(SIZE_CAP)) begin
      n = N_W'(SIZE_CAP);
    end
    return n;
  endfunction

  // ceil(log2(n)): count the powers of two below n
  function automatic logic [STEP_W-1:0] step_count(input logic [N_W-1:0] n);
    logic [STEP_W-1:0] s;
    s = '0;
    for (int i = 0; i < MAX_STEPS + 1; i++) begin
      if ((N_W + 1)'(1 << i) < {1'b0, n}) begin
        s = s + STEP_W'(1);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/agss_if.sv
// handshake channel interfaces for step requests and slice results
// depends on agss_pkg
`default_nettype none

interface agss_req_if;
  import agss_pkg::*;
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step;
  modport source (output valid, output step, input ready);
  modport sink   (input valid, input step, output ready);
endinterface

interface agss_rsp_if;
  import agss_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] send_to;
  logic [IDX_W-1:0] recv_from;
  logic [CNT_W-1:0] slice_count;
  logic [IDX_W-1:0] tx_slice;
  logic [IDX_W-1:0] rx_slice;
  logic             last;
  logic             status;
  modport source (output valid, output send_to, output recv_from, output slice_count,
                  output tx_slice, output rx_slice, output last, output status,
                  input ready);
  modport sink   (input valid, input send_to, input recv_from, input slice_count,
                  input tx_slice, input rx_slice, input last, input status,
                  output ready);
endinterface

`default_nettype wire

FILE: src/agss_modunit.sv
// shared modular add/subtract unit: y = (a + b - c), less m once if not below m
// depends on agss_pkg
`default_nettype none

module agss_modunit
  import agss_pkg::*;
(
  input  unit_req_t         req,
  output logic [UNIT_W-1:0] y
);

  logic [UNIT_W-1:0] x;

  always_comb begin
    x = req.a + req.b - req.c;
    if (x >= req.m) begin
      y = x - req.m;
    end else begin
      y = x;
    end
  end

endmodule

`default_nettype wire

FILE: src/agss_ctrl.sv
// sequencer driving the shared modular unit, one step request at a time
// depends on agss_pkg and agss_modunit
`default_nettype none

module agss_ctrl
  import agss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [N_W-1:0]    n,
  input  logic [STEP_W-1:0] steps,
  input  logic [IDX_W-1:0]  my_rank,
  input  logic              start,
  input  logic [STEP_W-1:0] step_in,
  input  logic              out_free,
  output logic              idle,
  output logic              load,
  output result_t           res
);

  state_t state, state_next;

  logic [STEP_W-1:0] step_q;
  logic              err;
  logic [RED_W-1:0]  j;
  logic [IDX_W-1:0]  me;
  logic [IDX_W-1:0]  send_to, recv_from, ddm, tx, rx, k;
  logic [CNT_W-1:0]  cnt;

  unit_req_t         ureq;
  logic [UNIT_W-1:0] uy;

  logic [STEP_W-1:0] shamt;
  logic [STEP_W-1:0] cnt_sh;
  logic [N_W-1:0]    d, dd;
  logic [N_W:0]      cnt_sum;
  logic              is_last;

  agss_modunit u_mod (.req(ureq), .y(uy));

  // distance and slice count of the stored step
  always_comb begin
    shamt   = steps - STEP_W'(1) - step_q;
    cnt_sh  = steps - step_q;
    d       = N_W'(1) << shamt;
    dd      = d << 1;
    cnt_sum = {1'b0, n} - (N_W + 1)'(1) + {1'b0, d};
    is_last = err || (k == cnt - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ureq       = '0;
    load       = 1'b0;
    idle       = (state == ST_IDLE);
    res        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (step_in >= steps) ? ST_OUT : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        ureq.a = UNIT_W'(me);
        ureq.m = UNIT_W'(n) << j;
        if (j == '0) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        ureq.a = UNIT_W'(me);
        ureq.b = UNIT_W'(d);
        ureq.m = UNIT_W'(n);
        state_next = ST_RECV;
      end
      ST_RECV: begin
        ureq.a = UNIT_W'(me);
        ureq.b = UNIT_W'(n);
        ureq.c = UNIT_W'(d);
        ureq.m = UNIT_W'(n);
        state_next = ST_DDM;
      end
      ST_DDM: begin
        ureq.a = UNIT_W'(dd);
        ureq.m = UNIT_W'(n);
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!err) begin
          res.send_to     = send_to;
          res.recv_from   = recv_from;
          res.slice_count = cnt;
          res.tx_slice    = tx;
          res.rx_slice    = rx;
        end
        res.last   = is_last;
        res.status = err;
        if (out_free) begin
          load       = 1'b1;
          state_next = is_last ? ST_IDLE : ST_NEXT_TX;
        end
      end
      ST_NEXT_TX: begin
        ureq.a = UNIT_W'(tx);
        ureq.b = UNIT_W'(n);
        ureq.c = UNIT_W'(ddm);
        ureq.m = UNIT_W'(n);
        state_next = ST_NEXT_RX;
      end
      ST_NEXT_RX: begin
        ureq.a = UNIT_W'(rx);
        ureq.b = UNIT_W'(n);
        ureq.c = UNIT_W'(ddm);
        ureq.m = UNIT_W'(n);
        state_next = ST_OUT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          step_q <= step_in;
          err    <= (step_in >= steps);
          me     <= my_rank;
          j      <= RED_W'(IDX_W - 1);
          k      <= '0;
        end
      end
      ST_REDUCE: begin
        me <= uy[IDX_W-1:0];
        j  <= j - RED_W'(1);
      end
      ST_SEND: begin
        send_to <= uy[IDX_W-1:0];
        cnt     <= CNT_W'(cnt_sum >> cnt_sh);
        tx      <= me;
      end
      ST_RECV: begin
        recv_from <= uy[IDX_W-1:0];
        rx        <= uy[IDX_W-1:0];
      end
      ST_DDM: begin
        ddm <= uy[IDX_W-1:0];
      end
      ST_OUT: begin
        if (out_free && !is_last) begin
          k <= k + IDX_W'(1);
        end
      end
      ST_NEXT_TX: tx <= uy[IDX_W-1:0];
      ST_NEXT_RX: rx <= uy[IDX_W-1:0];
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/allgather_step_schedule.sv
// top level of the all-gather step schedule: config registers, output register
// depends on agss_pkg, agss_if, agss_ctrl
//
//   port      dir   handshake      payload
//   req       sink  valid/ready    step
//   rsp       src   valid/ready    send_to recv_from slice_count tx_slice rx_slice last status
//   cfg_*     in    cfg_we         cfg_index, cfg_data (rank_size, my_rank_index)
//
// an out-of-range step goes straight to the output state for its single error item
// a valid step reduces the rank index modulo the group size on the shared modular
// unit in ST_REDUCE, works out peers and slice stride in ST_SEND, ST_RECV and ST_DDM,
// then gives each item from ST_OUT, which waits while the output register is full,
// and advances the slices in ST_NEXT_TX and ST_NEXT_RX; rst (synchronous) clears
// the sequencer, the output valid and the registers to rank_size 1 and my_rank_index 0;
// a stalled item holds in the output register while the sequencer already works out the next slice
`default_nettype none

module allgather_step_schedule
  import agss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  agss_req_if.sink          req,
  agss_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // configuration registers
  logic [CFG_W-1:0] rank_size;
  logic [IDX_W-1:0] my_rank_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_size     <= CFG_W'(1);
      my_rank_index <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANK_SIZE: rank_size     <= cfg_data;
        CFG_MY_RANK:   my_rank_index <= cfg_data[IDX_W-1:0];
      endcase
    end
  end

  // group size, step count follow the registers; user keeps them stable while busy, not enforced
  logic [N_W-1:0]    n;
  logic [STEP_W-1:0] steps;

  assign n     = eff_size(rank_size);
  assign steps = step_count(n);

  // sequencer
  logic    idle, load, start, out_valid;
  result_t res, out_q;

  assign start     = req.valid && req.ready;
  assign req.ready = idle;

  agss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .n        (n),
    .steps    (steps),
    .my_rank  (my_rank_index),
    .start    (start),
    .step_in  (req.step),
    .out_free (!out_valid),
    .idle     (idle),
    .load     (load),
    .res      (res)
  );

  // output register, loaded only when empty so items stay in order
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.send_to     = out_q.send_to;
  assign rsp.recv_from   = out_q.recv_from;
  assign rsp.slice_count = out_q.slice_count;
  assign rsp.tx_slice    = out_q.tx_slice;
  assign rsp.rx_slice    = out_q.rx_slice;
  assign rsp.last        = out_q.last;
  assign rsp.status      = out_q.status;

endmodule

`default_nettype wire

FILE: bench/tb_allgather_step_schedule.sv
// self-checking bench for allgather_step_schedule: step requests in, slice items out
// predicts every slice item of a step from its own copy of the two registers
// depends on agss_pkg, agss_if and the rtl of allgather_step_schedule
`default_nettype none

module tb_allgather_step_schedule
  import agss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // receiver hold-off: starts after this many accepted steps, lasts this many cycles
  localparam int HOLD_AT_STEP = 45;
  localparam int HOLD_CYCLES  = 400;
  localparam int TARGET_STEPS = 410;
  localparam int SETTLE       = 30;

  typedef struct {
    logic [STEP_W-1:0] step;
    int                gap;
  } step_req_t;

  logic clk = 1'b0;
  logic rst;
  logic              cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  agss_req_if step_ch ();
  agss_rsp_if slice_ch ();

  allgather_step_schedule uut (
    .clk       (clk),
    .rst       (rst),
    .req       (step_ch),
    .rsp       (slice_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // bench copy of the configuration registers
  logic [CFG_W-1:0] group_raw = CFG_W'(1);
  logic [IDX_W-1:0] rank_raw  = '0;

  step_req_t pending_steps[$];
  result_t   expected_slices[$];
  int        steps_accepted = 0;
  int        errors         = 0;
  int        step_gap_cnt;
  int        slice_wait;
  int        hold_left;
  bit        hold_done;
  bit        calm = 1'b0;   // no idling on either side while set

  // group size as the block sees it: zero reads as one, big values saturate
  function automatic int group_size(input logic [CFG_W-1:0] raw);
    int n;
    n = int'(raw);
    if (n == 0) n = 1;
    if (n > SIZE_CAP) n = SIZE_CAP;
    return n;
  endfunction

  // number of halving steps, ceil(log2(n))
  function automatic int schedule_depth(input int n);
    int s;
    s = 0;
    while ((1 << s) < n) s++;
    return s;
  endfunction

  // works out every slice item one step request gives
  function automatic void predict_slices(input logic [STEP_W-1:0] s);
    int n, depth, me, d, dd, cnt, tx, rx;
    result_t r;
    n = group_size(group_raw);
    depth = schedule_depth(n);
    r = '0;
    if (int'(s) >= depth) begin
      // out-of-range step: one error item with all other fields zero
      r.last = 1'b1;
      r.status = 1'b1;
      expected_slices.insert(expected_slices.size(), r);
      return;
    end
    me = int'(rank_raw) % n;
    d = 1 << (depth - 1 - int'(s));
    dd = 2 * d;
    cnt = (n - 1 + d) / dd;
    tx = me;
    rx = (me + n - d) % n;
    for (int k = 0; k < cnt; k++) begin
      r.send_to     = IDX_W'((me + d) % n);
      r.recv_from   = IDX_W'((me + n - d) % n);
      r.slice_count = CNT_W'(cnt);
      r.tx_slice    = IDX_W'(tx);
      r.rx_slice    = IDX_W'(rx);
      r.last        = (k + 1 == cnt);
      r.status      = 1'b0;
      expected_slices.insert(expected_slices.size(), r);
      tx = (tx + n - (dd % n)) % n;
      rx = (rx + n - (dd % n)) % n;
    end
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // driver: offers queued steps, each after its own gap
  always @(posedge clk) begin
    step_req_t nxt;
    if (rst) begin
      step_ch.valid <= 1'b0;
      step_ch.step <= '0;
      step_gap_cnt <= 0;
    end else if (!step_ch.valid || step_ch.ready) begin
      if (step_ch.valid) begin
        predict_slices(step_ch.step);
        steps_accepted <= steps_accepted + 1;
      end
      if (pending_steps.size() != 0 && step_gap_cnt >= pending_steps[0].gap) begin
        nxt = pending_steps.pop_front();
        step_ch.valid <= 1'b1;
        step_ch.step <= nxt.step;
        step_gap_cnt <= 0;
      end else begin
        step_ch.valid <= 1'b0;
        if (pending_steps.size() != 0) step_gap_cnt <= step_gap_cnt + 1;
      end
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && steps_accepted == HOLD_AT_STEP) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor: random stall before each slice item unless calm, compares against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    int wait_next;
    if (rst) begin
      slice_ch.ready <= 1'b0;
      slice_wait <= 0;
    end else begin
      if (slice_ch.valid && slice_ch.ready) begin
        if (expected_slices.size() == 0) begin
          $error("slice item with nothing expected: tx_slice %0d rx_slice %0d",
                 slice_ch.tx_slice, slice_ch.rx_slice);
          errors++;
        end else begin
          want = expected_slices.pop_front();
          check_field("send_to", want.send_to, slice_ch.send_to);
          check_field("recv_from", want.recv_from, slice_ch.recv_from);
          check_field("slice_count", want.slice_count, slice_ch.slice_count);
          check_field("tx_slice", want.tx_slice, slice_ch.tx_slice);
          check_field("rx_slice", want.rx_slice, slice_ch.rx_slice);
          check_field("last", want.last, slice_ch.last);
          check_field("status", want.status, slice_ch.status);
        end
        wait_next = calm ? 0 : $urandom_range(0, 15);
      end else begin
        wait_next = (slice_wait != 0) ? slice_wait - 1 : 0;
      end
      slice_wait <= wait_next;
      slice_ch.ready <= (wait_next == 0) && (hold_left == 0);
    end
  end

  // a config write, only ever issued while the block is idle
  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_RANK_SIZE) begin
      group_raw = val;
    end else begin
      rank_raw = val[IDX_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_group(input logic [CFG_W-1:0] ranks, input logic [CFG_W-1:0] me);
    write_reg(CFG_RANK_SIZE, ranks);
    write_reg(CFG_MY_RANK, me);
  endtask

  // queue one step item; its gap follows the idling mode of the phase
  function automatic void queue_step(input int s);
    step_req_t it;
    it.step = STEP_W'(s);
    it.gap = calm ? 0 : $urandom_range(0, 15);
    pending_steps.insert(pending_steps.size(), it);
  endfunction

  // sender pause: everything offered, accepted and answered, then an idle settle time
  task automatic drain();
    @(negedge clk);
    while (pending_steps.size() != 0 || step_ch.valid || expected_slices.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int total, depth, n_items, pick, phase;
    logic [CFG_W-1:0] ranks;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    step_ch.valid = 1'b0;
    step_ch.step = '0;
    slice_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // reset values: a single rank has no steps, so only error items
    @(negedge clk);
    queue_step(0);
    queue_step(7);
    drain();

    // rank size zero reads as one, index out of range folds to zero
    set_group(7'd0, 7'd5);
    @(negedge clk);
    queue_step(0);
    drain();

    // two ranks: one step, then out of range
    set_group(7'd2, 7'd1);
    @(negedge clk);
    queue_step(0);
    queue_step(1);
    drain();

    // full group, highest index: every step plus the two beyond
    set_group(7'd64, 7'd63);
    @(negedge clk);
    for (int s = 0; s < 8; s++) queue_step(s);
    drain();

    // oversized group saturates; upper bit of the index write is dropped
    set_group(7'd127, 7'h45);
    @(negedge clk);
    queue_step(0);
    queue_step(3);
    queue_step(5);
    drain();

    // non power of two group sizes, index beyond the group in the second
    set_group(7'd5, 7'd4);
    @(negedge clk);
    for (int s = 0; s < 4; s++) queue_step(s);
    drain();

    set_group(7'd33, 7'd40);
    @(negedge clk);
    queue_step(0);
    queue_step(5);
    queue_step(6);
    drain();

    // --- random part ---
    // first phase is long and wide so the receiver hold-off backs the block up
    total = steps_accepted;
    phase = 0;
    while (total < TARGET_STEPS) begin
      if (phase == 0) begin
        ranks = 7'd64;
        n_items = 50;
        calm = 1'b0;
      end else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: begin
            ranks = CFG_W'($urandom_range(0, 1));
          end
          1: begin
            ranks = CFG_W'($urandom_range(65, 127));
          end
          2, 3: begin
            ranks = CFG_W'(1 << $urandom_range(1, 6));
          end
          default: begin
            ranks = CFG_W'($urandom_range(2, 64));
          end
        endcase
        n_items = $urandom_range(10, 40);
        calm = ($urandom_range(0, 3) == 0);
      end
      // stop close to the target count
      if (n_items > TARGET_STEPS - total) n_items = TARGET_STEPS - total;
      set_group(ranks, CFG_W'($urandom_range(0, 127)));
      depth = schedule_depth(group_size(ranks));
      @(negedge clk);
      for (int i = 0; i < n_items; i++) begin
        // mostly steps inside the schedule, some beyond it
        if (depth > 0 && $urandom_range(0, 9) < 8) begin
          queue_step($urandom_range(0, depth - 1));
        end else begin
          queue_step($urandom_range(depth, 7));
        end
      end
      drain();
      total = steps_accepted;
      phase++;
    end

    calm = 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && expected_slices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
